[hdl/voxel_grid_downsampler_macros.svh]
// Assertion macros for the voxel grid downsampler.
`ifndef VOXEL_GRID_DOWNSAMPLER_MACROS_SVH
`define VOXEL_GRID_DOWNSAMPLER_MACROS_SVH

// Condition holds at every edge out of reset.
`define VGD_ASSERT_NOW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define VGD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define VGD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/vgd_pkg.sv]
// Shared types and constants of the voxel grid downsampler.
package vgd_pkg;

	localparam int MAX_VOXELS   = 1024;
	localparam int HASH_BUCKETS = 2048;

	localparam int SLOT_W  = $clog2(MAX_VOXELS);
	localparam int CNT_W   = SLOT_W + 1;
	localparam int HASH_W  = $clog2(HASH_BUCKETS);
	localparam int PROBE_W = HASH_W + 1;

	localparam int COORD_W = 32;
	localparam int NORM_W  = 16;
	localparam int SUM_W   = 48;
	localparam int IDX_W   = 32;
	localparam int DIV_W   = SUM_W;
	localparam int DVS_W   = 32;
	localparam int DSTEP_W = $clog2(DIV_W + 1);
	localparam int VS_W    = 31;

	localparam logic [VS_W-1:0] VOXEL_SIZE_RST = VS_W'(65536);

	localparam logic [31:0] HASH_CX = 32'd73856093;
	localparam logic [31:0] HASH_CY = 32'd19349663;
	localparam logic [31:0] HASH_CZ = 32'd83492791;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [2:0] ST_NEW     = 3'd0;
	localparam logic [2:0] ST_MERGED  = 3'd1;
	localparam logic [2:0] ST_SKIPPED = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_READ_OK = 3'd4;
	localparam logic [2:0] ST_BAD     = 3'd5;

	localparam logic [1:0] CFG_VOXEL_SIZE = 2'd0;
	localparam logic [1:0] CFG_CENTROID   = 2'd1;
	localparam logic [1:0] CFG_DISCARD    = 2'd2;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV_GO,
		S_DIV_WAIT,
		S_PROBE,
		S_BKT,
		S_CMP,
		S_MERGE,
		S_NEW,
		S_RD_MEM,
		S_RD_WAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic        [VS_W-1:0] voxel_size;
		logic                   centroid;
		logic                   discard;
	} cfg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] kx;
		logic signed [COORD_W-1:0] ky;
		logic signed [COORD_W-1:0] kz;
		logic signed [SUM_W-1:0]   sx;
		logic signed [SUM_W-1:0]   sy;
		logic signed [SUM_W-1:0]   sz;
		logic signed [SUM_W-1:0]   snx;
		logic signed [SUM_W-1:0]   sny;
		logic signed [SUM_W-1:0]   snz;
		logic        [31:0]        cnt;
		logic        [IDX_W-1:0]   first;
	} vox_rec_t;

	typedef struct packed {
		logic                    start;
		logic                    floor_div;
		logic                    short_div;
		logic signed [DIV_W-1:0] dividend;
		logic        [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [DIV_W-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic        [2:0]         status;
		logic        [9:0]         slot;
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic signed [COORD_W-1:0] out_z;
		logic signed [NORM_W-1:0]  out_nx;
		logic signed [NORM_W-1:0]  out_ny;
		logic signed [NORM_W-1:0]  out_nz;
		logic        [IDX_W-1:0]   source_index;
		logic        [31:0]        members;
		logic        [10:0]        voxel_total;
	} res_t;

endpackage

[hdl/vgd_if.sv]
// Channel interfaces: point requests, results and configuration writes.
interface vgd_pt_if;
	import vgd_pkg::*;
	logic                      valid;
	logic                      ready;
	logic        [1:0]         op;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;
	logic signed [COORD_W-1:0] coord_z;
	logic signed [NORM_W-1:0]  normal_x;
	logic signed [NORM_W-1:0]  normal_y;
	logic signed [NORM_W-1:0]  normal_z;
	logic                      finite;
	logic        [9:0]         read_slot;

	modport source (output valid, op, coord_x, coord_y, coord_z, normal_x, normal_y,
		normal_z, finite, read_slot, input ready);
	modport sink (input valid, op, coord_x, coord_y, coord_z, normal_x, normal_y,
		normal_z, finite, read_slot, output ready);
endinterface

interface vgd_res_if;
	import vgd_pkg::*;
	logic                      valid;
	logic                      ready;
	logic        [2:0]         status;
	logic        [9:0]         slot;
	logic signed [COORD_W-1:0] out_x;
	logic signed [COORD_W-1:0] out_y;
	logic signed [COORD_W-1:0] out_z;
	logic signed [NORM_W-1:0]  out_nx;
	logic signed [NORM_W-1:0]  out_ny;
	logic signed [NORM_W-1:0]  out_nz;
	logic        [IDX_W-1:0]   source_index;
	logic        [31:0]        members;
	logic        [10:0]        voxel_total;

	modport source (output valid, status, slot, out_x, out_y, out_z, out_nx, out_ny,
		out_nz, source_index, members, voxel_total, input ready);
	modport sink (input valid, status, slot, out_x, out_y, out_z, out_nx, out_ny,
		out_nz, source_index, members, voxel_total, output ready);
endinterface

interface vgd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hdl/vgd_div.sv]
// Shared radix-2 restoring divider, truncating or floor quotient.
module vgd_div (
	input  logic               clk,
	input  logic               arst_n,
	input  vgd_pkg::div_req_t  req,
	output vgd_pkg::div_rsp_t  rsp
);
	import vgd_pkg::*;

	logic                    busy_q;
	logic                    done_q;
	logic [DSTEP_W-1:0]      cnt_q;
	logic [DIV_W-1:0]        dq_q;
	logic [DVS_W-1:0]        rem_q;
	logic [DVS_W-1:0]        dvs_q;
	logic                    neg_q;
	logic                    floor_q;
	logic [DVS_W:0]          trial;
	logic [DVS_W:0]          diff;
	logic                    ge;
	logic [DIV_W-1:0]        mag;

	assign trial = {rem_q, dq_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};
	assign mag   = req.dividend[DIV_W-1] ? DIV_W'(-req.dividend) : DIV_W'(req.dividend);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DSTEP_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.short_div ? DSTEP_W'(COORD_W) : DSTEP_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DSTEP_W'(1);
				if (cnt_q == DSTEP_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q    <= req.short_div ? (mag << (DIV_W - COORD_W)) : mag;
			rem_q   <= '0;
			dvs_q   <= req.divisor;
			neg_q   <= req.dividend[DIV_W-1];
			floor_q <= req.floor_div;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			dq_q  <= {dq_q[DIV_W-2:0], ge};
		end
	end

	always_comb begin
		rsp.done = done_q;
		if (!neg_q)
			rsp.quot = dq_q;
		else if (floor_q && (rem_q != '0))
			rsp.quot = ~dq_q;
		else
			rsp.quot = -dq_q;
	end

endmodule

[hdl/vgd_ctrl.sv]
// Sequencer with bucket table and voxel store.
`include "voxel_grid_downsampler_macros.svh"

module vgd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	vgd_pt_if.sink            pt,
	input  vgd_pkg::cfg_t     cfg,
	output vgd_pkg::res_t     res,
	output logic              res_valid,
	input  logic              res_ready,
	output vgd_pkg::div_req_t div_req,
	input  vgd_pkg::div_rsp_t div_rsp
);
	import vgd_pkg::*;

	state_t                    state_q, state_d;
	logic                      clr_op_q;
	logic [HASH_W-1:0]         clr_cnt_q;
	logic [IDX_W-1:0]          pc_q;
	logic [CNT_W-1:0]          vcnt_q;
	logic [2:0]                div_i_q;
	logic [PROBE_W-1:0]        probe_q;

	logic [1:0]                op_q;
	logic signed [COORD_W-1:0] cx_q, cy_q, cz_q;
	logic signed [NORM_W-1:0]  nx_q, ny_q, nz_q;
	logic [SLOT_W-1:0]         rslot_q;
	logic [IDX_W-1:0]          idx_q;
	logic signed [COORD_W-1:0] kx_q, ky_q, kz_q;
	logic [HASH_W-1:0]         hash_q;
	logic [SLOT_W-1:0]         slot_q;
	res_t                      res_q;
	res_t                      res_init;

	logic [CNT_W-1:0]          bkt_mem [HASH_BUCKETS];
	logic [CNT_W-1:0]          bkt_rd_q;
	vox_rec_t                  vox_mem [MAX_VOXELS];
	vox_rec_t                  vox_rd_q;

	logic                      accept;
	logic                      bkt_we, bkt_re, vox_we, vox_re;
	logic [HASH_W-1:0]         bkt_wa, bkt_ra;
	logic [CNT_W-1:0]          bkt_wd;
	logic [SLOT_W-1:0]         vox_wa, vox_ra;
	vox_rec_t                  vox_wd;
	logic                      key_hit;
	logic                      can_merge;
	logic [31:0]               hash_c;
	logic [HASH_W-1:0]         hash_p;
	logic [COORD_W-1:0]        key_new;

	assign accept    = pt.valid && pt.ready;
	assign key_hit   = (vox_rd_q.kx == kx_q) && (vox_rd_q.ky == ky_q) && (vox_rd_q.kz == kz_q);
	assign can_merge = cfg.centroid && (vox_rd_q.cnt != '1);
	assign key_new   = div_rsp.quot[COORD_W-1:0];

	always_comb begin
		case (div_i_q)
			3'd0:    hash_c = HASH_CX;
			3'd1:    hash_c = HASH_CY;
			default: hash_c = HASH_CZ;
		endcase
		hash_p = HASH_W'(key_new[HASH_W-1:0] * hash_c[HASH_W-1:0]);
	end

	always_comb begin
		res_init = '0;
		case (pt.op)
			OP_ADD:   res_init.status = ST_SKIPPED;
			OP_READ: begin
				res_init.status = ST_BAD;
				res_init.slot   = pt.read_slot;
			end
			OP_CLEAR: res_init.status = ST_NEW;
			default:  res_init.status = ST_BAD;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:
				if (clr_cnt_q == HASH_W'(HASH_BUCKETS - 1))
					state_d = clr_op_q ? S_DONE : S_IDLE;
			S_IDLE:
				if (pt.valid) begin
					case (pt.op)
						OP_ADD:   state_d = (cfg.discard && !pt.finite) ? S_DONE : S_DIV_GO;
						OP_READ:  state_d = (32'(pt.read_slot) >= 32'(vcnt_q)) ? S_DONE : S_RD_MEM;
						OP_CLEAR: state_d = S_CLEAR;
						default:  state_d = S_DONE;
					endcase
				end
			S_DIV_GO:   state_d = S_DIV_WAIT;
			S_DIV_WAIT:
				if (div_rsp.done) begin
					if (op_q == OP_ADD)
						state_d = (div_i_q == 3'd2) ? S_PROBE : S_DIV_GO;
					else
						state_d = (div_i_q == 3'd5) ? S_DONE : S_DIV_GO;
				end
			S_PROBE:    state_d = S_BKT;
			S_BKT:
				if (bkt_rd_q == '0)
					state_d = (vcnt_q >= CNT_W'(MAX_VOXELS)) ? S_DONE : S_NEW;
				else
					state_d = S_CMP;
			S_CMP:
				if (key_hit)
					state_d = S_MERGE;
				else if (probe_q == PROBE_W'(HASH_BUCKETS - 1))
					state_d = S_DONE;
				else
					state_d = S_PROBE;
			S_MERGE:    state_d = S_DONE;
			S_NEW:      state_d = S_DONE;
			S_RD_MEM:   state_d = S_RD_WAIT;
			S_RD_WAIT:  state_d = S_DIV_GO;
			S_DONE:
				if (res_ready)
					state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pt.ready          = (state_q == S_IDLE);
		res_valid         = (state_q == S_DONE);
		bkt_we            = 1'b0;
		bkt_wa            = hash_q;
		bkt_wd            = CNT_W'(vcnt_q + CNT_W'(1));
		bkt_re            = 1'b0;
		bkt_ra            = hash_q;
		vox_we            = 1'b0;
		vox_wa            = slot_q;
		vox_wd            = vox_rd_q;
		vox_re            = 1'b0;
		vox_ra            = SLOT_W'(bkt_rd_q - CNT_W'(1));
		div_req.start     = 1'b0;
		div_req.floor_div = (op_q == OP_ADD);
		div_req.short_div = (op_q == OP_ADD);
		div_req.dividend  = '0;
		div_req.divisor   = '0;
		if (op_q == OP_ADD) begin
			div_req.divisor = (cfg.voxel_size == '0) ? DVS_W'(1) : DVS_W'(cfg.voxel_size);
			case (div_i_q)
				3'd0:    div_req.dividend = DIV_W'(cx_q);
				3'd1:    div_req.dividend = DIV_W'(cy_q);
				default: div_req.dividend = DIV_W'(cz_q);
			endcase
		end else begin
			div_req.divisor = (vox_rd_q.cnt == '0) ? DVS_W'(1) : vox_rd_q.cnt;
			case (div_i_q)
				3'd0:    div_req.dividend = vox_rd_q.sx;
				3'd1:    div_req.dividend = vox_rd_q.sy;
				3'd2:    div_req.dividend = vox_rd_q.sz;
				3'd3:    div_req.dividend = vox_rd_q.snx;
				3'd4:    div_req.dividend = vox_rd_q.sny;
				default: div_req.dividend = vox_rd_q.snz;
			endcase
		end
		unique case (state_q)
			S_CLEAR: begin
				bkt_we = 1'b1;
				bkt_wa = clr_cnt_q;
				bkt_wd = '0;
			end
			S_DIV_GO: div_req.start = 1'b1;
			S_PROBE:  bkt_re = 1'b1;
			S_BKT:    vox_re = (bkt_rd_q != '0);
			S_MERGE: begin
				vox_we        = can_merge;
				vox_wd.sx     = vox_rd_q.sx + SUM_W'(cx_q);
				vox_wd.sy     = vox_rd_q.sy + SUM_W'(cy_q);
				vox_wd.sz     = vox_rd_q.sz + SUM_W'(cz_q);
				vox_wd.snx    = vox_rd_q.snx + SUM_W'(nx_q);
				vox_wd.sny    = vox_rd_q.sny + SUM_W'(ny_q);
				vox_wd.snz    = vox_rd_q.snz + SUM_W'(nz_q);
				vox_wd.cnt    = vox_rd_q.cnt + 32'd1;
			end
			S_NEW: begin
				bkt_we       = 1'b1;
				vox_we       = 1'b1;
				vox_wa       = vcnt_q[SLOT_W-1:0];
				vox_wd.kx    = kx_q;
				vox_wd.ky    = ky_q;
				vox_wd.kz    = kz_q;
				vox_wd.sx    = SUM_W'(cx_q);
				vox_wd.sy    = SUM_W'(cy_q);
				vox_wd.sz    = SUM_W'(cz_q);
				vox_wd.snx   = SUM_W'(nx_q);
				vox_wd.sny   = SUM_W'(ny_q);
				vox_wd.snz   = SUM_W'(nz_q);
				vox_wd.cnt   = 32'd1;
				vox_wd.first = idx_q;
			end
			S_RD_MEM: begin
				vox_re = 1'b1;
				vox_ra = rslot_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (bkt_we)
			bkt_mem[bkt_wa] <= bkt_wd;
		if (bkt_re)
			bkt_rd_q <= bkt_mem[bkt_ra];
	end

	always_ff @(posedge clk) begin
		if (vox_we)
			vox_mem[vox_wa] <= vox_wd;
		if (vox_re)
			vox_rd_q <= vox_mem[vox_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_op_q  <= 1'b0;
			clr_cnt_q <= '0;
			pc_q      <= '0;
			vcnt_q    <= '0;
			div_i_q   <= '0;
			probe_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR)
				clr_cnt_q <= clr_cnt_q + HASH_W'(1);
			if (accept) begin
				clr_op_q <= (pt.op == OP_CLEAR);
				div_i_q  <= '0;
				probe_q  <= '0;
				if (pt.op == OP_CLEAR) begin
					pc_q   <= '0;
					vcnt_q <= '0;
				end else if (pt.op == OP_ADD && pc_q != '1)
					pc_q <= pc_q + IDX_W'(1);
			end
			if (state_q == S_DIV_WAIT && div_rsp.done)
				div_i_q <= div_i_q + 3'd1;
			if (state_q == S_CMP && !key_hit)
				probe_q <= probe_q + PROBE_W'(1);
			if (state_q == S_NEW)
				vcnt_q <= vcnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= pt.op;
			cx_q    <= pt.coord_x;
			cy_q    <= pt.coord_y;
			cz_q    <= pt.coord_z;
			nx_q    <= pt.normal_x;
			ny_q    <= pt.normal_y;
			nz_q    <= pt.normal_z;
			rslot_q <= SLOT_W'(pt.read_slot);
			idx_q   <= pc_q;
			res_q   <= res_init;
		end
		unique case (state_q)
			S_DIV_WAIT:
				if (div_rsp.done) begin
					if (op_q == OP_ADD) begin
						case (div_i_q)
							3'd0:    kx_q <= key_new;
							3'd1:    ky_q <= key_new;
							default: kz_q <= key_new;
						endcase
						hash_q <= ((div_i_q == 3'd0) ? '0 : hash_q) ^ hash_p;
					end else begin
						case (div_i_q)
							3'd0:    res_q.out_x  <= div_rsp.quot[COORD_W-1:0];
							3'd1:    res_q.out_y  <= div_rsp.quot[COORD_W-1:0];
							3'd2:    res_q.out_z  <= div_rsp.quot[COORD_W-1:0];
							3'd3:    res_q.out_nx <= div_rsp.quot[NORM_W-1:0];
							3'd4:    res_q.out_ny <= div_rsp.quot[NORM_W-1:0];
							default: res_q.out_nz <= div_rsp.quot[NORM_W-1:0];
						endcase
					end
				end
			S_BKT: begin
				slot_q <= SLOT_W'(bkt_rd_q - CNT_W'(1));
				if (bkt_rd_q == '0)
					res_q.status <= ST_FULL;
			end
			S_CMP:
				if (!key_hit) begin
					hash_q       <= hash_q + HASH_W'(1);
					res_q.status <= ST_FULL;
				end
			S_MERGE: begin
				res_q.status       <= ST_MERGED;
				res_q.slot         <= 10'(slot_q);
				res_q.source_index <= vox_rd_q.first;
				res_q.members      <= can_merge ? vox_rd_q.cnt + 32'd1 : vox_rd_q.cnt;
			end
			S_NEW: begin
				res_q.status       <= ST_NEW;
				res_q.slot         <= 10'(vcnt_q);
				res_q.source_index <= idx_q;
				res_q.members      <= 32'd1;
			end
			S_RD_WAIT: begin
				res_q.status       <= ST_READ_OK;
				res_q.source_index <= vox_rd_q.first;
				res_q.members      <= vox_rd_q.cnt;
			end
			default: ;
		endcase
	end

	always_comb begin
		res             = res_q;
		res.voxel_total = 11'(vcnt_q);
	end

	`VGD_ASSERT_NOW(a_vcnt_cap, vcnt_q <= CNT_W'(MAX_VOXELS), "voxel count above capacity")
	`VGD_ASSERT_IMP(a_div_done, div_rsp.done, state_q == S_DIV_WAIT, "divider done out of wait")
	`VGD_ASSERT_NXT(a_new_inc, state_q == S_NEW, vcnt_q == $past(vcnt_q) + CNT_W'(1), "no count step")
	`VGD_ASSERT_IMP(a_clr_empty, state_q == S_CLEAR, vcnt_q == '0, "count held during clear")

endmodule

[hdl/voxel_grid_downsampler.sv]
// Voxel grid downsampler top level: config registers, sequencer, divider, result register.
//
// Channels: pt takes requests (add point, read slot, clear), res returns one result per
// request, cfg writes voxel_size (0), centroid_mode (1) and discard_invalid (2); cfg is
// always ready; it must be written only while no request is in flight (not enforced here).
// One request at a time; pt.ready is high only while the sequencer waits for work.
// Steps, all through one shared divider (one quotient bit per cycle):
//   add point: 3 key divisions, then the bucket probes.
//   read slot: 6 divisions; a bad slot or skipped point takes no division.
//   clear: a sweep of the bucket table, then the result.
// After reset the same sweep runs before the first request is taken; config
// writes are taken during it.
// Results sit in an output register; while res.ready is low the finished result holds and
// the next request can already be taken and worked on.
module voxel_grid_downsampler (
	input  logic       clk,
	input  logic       arst_n,
	vgd_pt_if.sink     pt,
	vgd_res_if.source  res,
	vgd_cfg_if.sink    cfg
);
	import vgd_pkg::*;

	cfg_t     cfg_q;
	res_t     res_c;
	res_t     out_q;
	logic     out_valid_q;
	logic     res_c_valid;
	logic     res_take;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign cfg.ready = 1'b1;
	assign res_take  = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.voxel_size <= VOXEL_SIZE_RST;
			cfg_q.centroid   <= 1'b1;
			cfg_q.discard    <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_VOXEL_SIZE: cfg_q.voxel_size <= cfg.data[VS_W-1:0];
				CFG_CENTROID:   cfg_q.centroid   <= cfg.data[0];
				CFG_DISCARD:    cfg_q.discard    <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_take)
			out_valid_q <= res_c_valid;
	end

	always_ff @(posedge clk) begin
		if (res_take && res_c_valid)
			out_q <= res_c;
	end

	assign res.valid        = out_valid_q;
	assign res.status       = out_q.status;
	assign res.slot         = out_q.slot;
	assign res.out_x        = out_q.out_x;
	assign res.out_y        = out_q.out_y;
	assign res.out_z        = out_q.out_z;
	assign res.out_nx       = out_q.out_nx;
	assign res.out_ny       = out_q.out_ny;
	assign res.out_nz       = out_q.out_nz;
	assign res.source_index = out_q.source_index;
	assign res.members      = out_q.members;
	assign res.voxel_total  = out_q.voxel_total;

	vgd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt        (pt),
		.cfg       (cfg_q),
		.res       (res_c),
		.res_valid (res_c_valid),
		.res_ready (res_take),
		.div_req   (div_req),
		.div_rsp   (div_rsp)
	);

	vgd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

[bench/tb_vgd_if.sv]
// Testbench copy note: interfaces are provided by the RTL; this file holds bench helpers.
`timescale 1ns / 100ps
package tb_vgd_pkg;
	import vgd_pkg::*;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] cx, cy, cz;
		logic [15:0] nx, ny, nz;
		logic        finite;
		logic [9:0]  rslot;
	} pt_req_t;

	typedef struct {
		logic [1:0]  index;
		logic [31:0] data;
	} cfg_wr_t;
endpackage

[bench/tb_top.sv]
// Self-checking bench for the voxel grid downsampler with a behavioral voxel table.
`timescale 1ns / 100ps
module tb_top;
	import vgd_pkg::*;
	import tb_vgd_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	vgd_pt_if  pt ();
	vgd_res_if res ();
	vgd_cfg_if cfg ();

	voxel_grid_downsampler dut (.clk(clk), .arst_n(arst_n), .pt(pt), .res(res), .cfg(cfg));

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// voxel table mirror
	logic [30:0]        vsize;
	logic               centroid, discard;
	logic [31:0]        pcount;
	int unsigned        nvox;
	int unsigned        bucket [HASH_BUCKETS];
	logic signed [31:0] vkx [MAX_VOXELS], vky [MAX_VOXELS], vkz [MAX_VOXELS];
	longint             vsx [MAX_VOXELS], vsy [MAX_VOXELS], vsz [MAX_VOXELS];
	longint             vnx [MAX_VOXELS], vny [MAX_VOXELS], vnz [MAX_VOXELS];
	logic [31:0]        vcnt [MAX_VOXELS], vfirst [MAX_VOXELS];

	res_t    expected_q [$];
	pt_req_t pending_q [$];
	cfg_wr_t cfg_q [$];
	int      errors = 0;
	int      send_idle_pct = 0, recv_stall_pct = 0;
	bit      hold_off = 0;
	longint  cycles = 0;

	function automatic void wipe_table();
		pcount = 0;
		nvox = 0;
		foreach (bucket[i]) bucket[i] = 0;
	endfunction

	function automatic void queue_req(pt_req_t p);
		pending_q = {pending_q, p};
	endfunction

	function automatic void queue_cfg(logic [1:0] idx, logic [31:0] d);
		cfg_wr_t w;
		w.index = idx;
		w.data = d;
		cfg_q = {cfg_q, w};
	endfunction

	function automatic logic signed [31:0] floor_div(longint c, longint d);
		longint q;
		q = c / d;
		if (c < 0 && (c % d) != 0)
			q = q - 1;
		return q[31:0];
	endfunction

	function automatic res_t predict_voxel(pt_req_t p);
		res_t r;
		longint cx, cy, cz, nx, ny, nz, d, n;
		logic signed [31:0] kx, ky, kz;
		logic [31:0] h, idx;
		int unsigned b, s, e;
		bit found, empty;
		r = '0;
		case (p.op)
			OP_ADD: begin
				idx = pcount;
				if (pcount != 32'hFFFF_FFFF)
					pcount++;
				if (discard && !p.finite) begin
					r.status = ST_SKIPPED;
				end else begin
					cx = longint'($signed(p.cx));
					cy = longint'($signed(p.cy));
					cz = longint'($signed(p.cz));
					nx = longint'($signed(p.nx));
					ny = longint'($signed(p.ny));
					nz = longint'($signed(p.nz));
					d = (vsize == 0) ? 1 : longint'(vsize);
					kx = floor_div(cx, d);
					ky = floor_div(cy, d);
					kz = floor_div(cz, d);
					h = (kx * HASH_CX) ^ (ky * HASH_CY) ^ (kz * HASH_CZ);
					b = h % HASH_BUCKETS;
					found = 0;
					empty = 0;
					s = 0;
					for (int i = 0; i < HASH_BUCKETS; i++) begin
						e = bucket[b];
						if (e == 0) begin
							empty = 1;
							break;
						end
						s = (e - 1) % MAX_VOXELS;
						if (vkx[s] == kx && vky[s] == ky && vkz[s] == kz) begin
							found = 1;
							break;
						end
						b = (b + 1) % HASH_BUCKETS;
					end
					if (found) begin
						if (centroid && vcnt[s] != 32'hFFFF_FFFF) begin
							vsx[s] += cx; vsy[s] += cy; vsz[s] += cz;
							vnx[s] += nx; vny[s] += ny; vnz[s] += nz;
							vcnt[s]++;
						end
						r.status = ST_MERGED;
					end else if (!empty || nvox >= MAX_VOXELS) begin
						r.status = ST_FULL;
					end else begin
						s = nvox++;
						bucket[b] = s + 1;
						vkx[s] = kx; vky[s] = ky; vkz[s] = kz;
						vsx[s] = cx; vsy[s] = cy; vsz[s] = cz;
						vnx[s] = nx; vny[s] = ny; vnz[s] = nz;
						vcnt[s] = 1;
						vfirst[s] = idx;
						r.status = ST_NEW;
					end
					if (r.status != ST_FULL) begin
						r.slot = s[9:0];
						r.source_index = vfirst[s];
						r.members = vcnt[s];
					end
				end
			end
			OP_READ: begin
				s = p.rslot;
				r.slot = p.rslot;
				if (s >= nvox) begin
					r.status = ST_BAD;
				end else begin
					n = (vcnt[s] == 0) ? 1 : longint'(vcnt[s]);
					r.status = ST_READ_OK;
					r.out_x = 32'(vsx[s] / n);
					r.out_y = 32'(vsy[s] / n);
					r.out_z = 32'(vsz[s] / n);
					r.out_nx = 16'(vnx[s] / n);
					r.out_ny = 16'(vny[s] / n);
					r.out_nz = 16'(vnz[s] / n);
					r.source_index = vfirst[s];
					r.members = vcnt[s];
				end
			end
			OP_CLEAR: begin
				wipe_table();
				r.status = ST_NEW;
			end
			default: r.status = ST_BAD;
		endcase
		r.voxel_total = nvox[10:0];
		return r;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt.valid <= 1'b0;
			pt.op <= OP_ADD;
			pt.coord_x <= '0; pt.coord_y <= '0; pt.coord_z <= '0;
			pt.normal_x <= '0; pt.normal_y <= '0; pt.normal_z <= '0;
			pt.finite <= 1'b0;
			pt.read_slot <= '0;
		end else if (!pt.valid || pt.ready) begin
			if (pt.valid)
				expected_q = {expected_q, predict_voxel('{pt.op, pt.coord_x, pt.coord_y,
					pt.coord_z, pt.normal_x, pt.normal_y, pt.normal_z, pt.finite,
					pt.read_slot})};
			if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				pt_req_t p;
				p = pending_q.pop_front();
				pt.valid <= 1'b1;
				pt.op <= p.op;
				pt.coord_x <= p.cx; pt.coord_y <= p.cy; pt.coord_z <= p.cz;
				pt.normal_x <= p.nx; pt.normal_y <= p.ny; pt.normal_z <= p.nz;
				pt.finite <= p.finite;
				pt.read_slot <= p.rslot;
			end else begin
				pt.valid <= 1'b0;
			end
		end
	end

	// config driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.valid <= 1'b0;
			cfg.index <= CFG_VOXEL_SIZE;
			cfg.data <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_VOXEL_SIZE: vsize = cfg.data[30:0];
					CFG_CENTROID:   centroid = cfg.data[0];
					CFG_DISCARD:    discard = cfg.data[0];
					default: ;
				endcase
			end
			if (cfg_q.size() > 0 && (!cfg.valid || cfg.ready)) begin
				cfg_wr_t w;
				w = cfg_q.pop_front();
				cfg.valid <= 1'b1;
				cfg.index <= w.index;
				cfg.data <= w.data;
			end else if (cfg.ready) begin
				cfg.valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			cycles <= cycles + 1;
			if (res.valid && res.ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result, status %0d", res.status);
					errors++;
				end else begin
					res_t x;
					x = expected_q.pop_front();
					if (res.status !== x.status) begin
						$error("status exp %0d got %0d", x.status, res.status); errors++; end
					if (res.slot !== x.slot) begin
						$error("slot exp %0d got %0d", x.slot, res.slot); errors++; end
					if (res.out_x !== x.out_x) begin
						$error("out_x exp %0d got %0d", x.out_x, res.out_x); errors++; end
					if (res.out_y !== x.out_y) begin
						$error("out_y exp %0d got %0d", x.out_y, res.out_y); errors++; end
					if (res.out_z !== x.out_z) begin
						$error("out_z exp %0d got %0d", x.out_z, res.out_z); errors++; end
					if (res.out_nx !== x.out_nx) begin
						$error("out_nx exp %0d got %0d", x.out_nx, res.out_nx); errors++; end
					if (res.out_ny !== x.out_ny) begin
						$error("out_ny exp %0d got %0d", x.out_ny, res.out_ny); errors++; end
					if (res.out_nz !== x.out_nz) begin
						$error("out_nz exp %0d got %0d", x.out_nz, res.out_nz); errors++; end
					if (res.source_index !== x.source_index) begin
						$error("source_index exp %0d got %0d", x.source_index, res.source_index);
						errors++;
					end
					if (res.members !== x.members) begin
						$error("members exp %0d got %0d", x.members, res.members); errors++; end
					if (res.voxel_total !== x.voxel_total) begin
						$error("voxel_total exp %0d got %0d", x.voxel_total, res.voxel_total);
						errors++;
					end
				end
			end
			res.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic pt_req_t make_point(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
		bit fin);
		pt_req_t p;
		p.op = OP_ADD;
		p.cx = cx; p.cy = cy; p.cz = cz;
		p.nx = $urandom; p.ny = $urandom; p.nz = $urandom;
		p.finite = fin;
		p.rslot = $urandom;
		return p;
	endfunction

	function automatic pt_req_t make_op(logic [1:0] op, logic [9:0] s);
		pt_req_t p;
		p = make_point($urandom, $urandom, $urandom, $urandom);
		p.op = op;
		p.rslot = s;
		return p;
	endfunction

	// sampled on the falling edge so the driver and monitor updates have settled
	task automatic drain();
		do
			@(negedge clk);
		while (pending_q.size() > 0 || pt.valid || expected_q.size() > 0);
		repeat (400) @(posedge clk);
	endtask

	task automatic set_cfg(logic [30:0] vs, bit cm, bit dc);
		queue_cfg(CFG_VOXEL_SIZE, {1'b0, vs});
		queue_cfg(CFG_CENTROID, {31'd0, cm});
		queue_cfg(CFG_DISCARD, {31'd0, dc});
		wait (cfg_q.size() == 0);
		repeat (3) @(posedge clk);
	endtask

	// random phase: clustered points so voxels repeat, plus reads, random points, invalid ops and clears
	task automatic random_phase(int count, int spread);
		logic [31:0] base;
		int r;
		base = $urandom;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 60)
				queue_req(make_point(base + $urandom_range(spread),
					base + $urandom_range(spread), base - $urandom_range(spread),
					$urandom_range(9) != 0));
			else if (r < 70)
				queue_req(make_point($urandom, $urandom, $urandom, $urandom));
			else if (r < 94)
				queue_req(make_op(OP_READ, $urandom_range(nvox + 3)));
			else if (r < 96)
				queue_req(make_op(OP_READ, $urandom));
			else if (r < 98)
				queue_req(make_op(2'd3, 0));
			else
				queue_req(make_op(OP_CLEAR, 0));
		end
	endtask

	initial begin
		vsize = VOXEL_SIZE_RST;
		centroid = 1;
		discard = 1;
		wipe_table();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed
		queue_req(make_op(OP_READ, 0));
		queue_req(make_point(32'h7FFF_FFFF, 32'h8000_0000, 0, 1));
		queue_req(make_point(32'h7FFF_0000, 32'h8000_0001, 32'hFFFF, 1));
		queue_req(make_point(32'hFFFF_FFFF, 32'h0001_0000, 32'h0, 0));
		queue_req(make_point(32'hFFFF_FFFF, 32'hFFFF_0000, 32'h1, 1));
		queue_req(make_point(32'hFFFF_0001, 32'hFFFF_0000, 32'h8000, 1));
		queue_req(make_op(OP_READ, 0));
		queue_req(make_op(OP_READ, 1));
		queue_req(make_op(OP_READ, 2));
		queue_req(make_op(OP_READ, 10'h3FF));
		queue_req(make_op(2'd3, 5));
		queue_req(make_op(OP_CLEAR, 0));
		queue_req(make_op(OP_READ, 0));
		drain();

		set_cfg(31'd0, 0, 0);
		queue_req(make_point(5, 5, 5, 0));
		queue_req(make_point(5, 5, 5, 1));
		queue_req(make_point(32'hFFFF_FFFF, 5, 5, 1));
		queue_req(make_op(OP_READ, 0));
		queue_req(make_op(OP_READ, 1));
		drain();
		set_cfg(31'h7FFF_FFFF, 1, 0);
		queue_req(make_point(32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
		queue_req(make_point(32'h7FFF_FFFE, 32'h8000_0000, 1, 1));
		queue_req(make_op(OP_READ, 2));
		queue_req(make_op(OP_READ, 3));
		drain();

		// random phases with several settings and idling patterns
		send_idle_pct = 0; recv_stall_pct = 0;
		set_cfg(VOXEL_SIZE_RST, 1, 1);
		random_phase(130, 32'h0004_0000);
		drain();
		send_idle_pct = 82; recv_stall_pct = 0;
		set_cfg(31'h0000_8000, 0, 1);
		random_phase(130, 32'h0002_0000);
		drain();
		send_idle_pct = 0; recv_stall_pct = 82;
		set_cfg(31'h0010_0000, 1, 0);
		random_phase(130, 32'h0040_0000);
		drain();
		send_idle_pct = 36; recv_stall_pct = 36;
		set_cfg(31'd1, 1, 1);
		random_phase(130, 8);
		drain();

		// long receiver hold-off while requests keep coming
		send_idle_pct = 0; recv_stall_pct = 0;
		hold_off = 1;
		random_phase(30, 32'h0002_0000);
		repeat (3000) @(posedge clk);
		hold_off = 0;
		drain();

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		if (cycles > 10_000_000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end
endmodule
